[design/rle_sprite_line_decoder_macros.svh]
// Assertion macros shared by the sprite line decoder RTL.
`ifndef RLE_SPRITE_LINE_DECODER_MACROS_SVH
`define RLE_SPRITE_LINE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rsld: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RSLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rsld: next-cycle check failed");

`endif

[design/rsld_pkg.sv]
// Types, codes and widths of the sprite scanline run-length decoder.
package rsld_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int WIDTH_W        = 11;
    localparam int POS_W          = 12;
    localparam int X_W            = 10;
    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int OUT_TDATA_W    = 32;
    localparam int OUT_TUSER_W    = 3;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_LIT  = 2'd2;
    localparam logic [1:0] PH_FILL = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SKIP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LINE_WIDTH = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_COMPRESSED = 3'h4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [X_W-1:0]    x;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] pix;
        logic              line_end;
        logic              overrun;
    } t_span;

endpackage

[design/rle_sprite_line_decoder.sv]
// Sprite scanline run-length decoder, one stream byte per beat.
// An accepted byte is held in an input register, then its span (if any) in a result register.
// One byte per cycle unless output stalls; the phase/pos update is one short add and compare.
// Reset (synchronous, active low): phase waits for a skip byte, position 0, registers 0.
`include "rle_sprite_line_decoder_macros.svh"

module rle_sprite_line_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // data_byte[7:0]
    input  logic [rsld_pkg::BYTE_W-1:0]         i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // span_x[9:0], span_length[17:10], pixel_value[25:18], zero[31:26]
    output logic [rsld_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // span_kind[1:0], overrun[2]
    output logic [rsld_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsld_pkg::PADDR_W-1:0]        paddr,
    input  logic [rsld_pkg::PDATA_W-1:0]        pwdata,
    output logic [rsld_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import rsld_pkg::*;

    localparam int WIDTH_CAP = (MAX_LINE_WIDTH > 2047) ? 2047 : MAX_LINE_WIDTH;

    logic [WIDTH_W-1:0] r_line_width;
    logic               r_compressed;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    logic [1:0]         r_phase;
    logic [POS_W-1:0]   r_pos;
    logic [BYTE_W-1:0]  r_rem;

    logic               r_out_valid;
    t_span              r_out;

    logic [1:0]         n_phase;
    logic [POS_W-1:0]   n_pos;
    logic [BYTE_W-1:0]  n_rem;
    t_span              n_out;
    logic               has_result;

    logic [WIDTH_W-1:0] eff_width;
    logic [POS_W-1:0]   w;
    logic [POS_W-1:0]   room;
    logic [POS_W-1:0]   sum;
    logic [BYTE_W-1:0]  rem_dec;
    logic [POS_W-1:0]   cnt_ext;
    logic               out_free;
    logic               advance;
    logic               apb_wr;

    // configuration port
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= '0;
            r_compressed <= 1'b0;
        end else if (apb_wr) begin
            if (paddr == ADDR_LINE_WIDTH) begin
                r_line_width <= pwdata[WIDTH_W-1:0];
            end
            if (paddr == ADDR_COMPRESSED) begin
                r_compressed <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            ADDR_LINE_WIDTH: prdata = {{(PDATA_W-WIDTH_W){1'b0}}, r_line_width};
            ADDR_COMPRESSED: prdata = {{(PDATA_W-1){1'b0}}, r_compressed};
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (out_free || !has_result);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // decode
    assign eff_width = (r_line_width > WIDTH_W'(WIDTH_CAP)) ? WIDTH_W'(WIDTH_CAP) : r_line_width;
    assign w         = {{(POS_W-WIDTH_W){1'b0}}, eff_width};
    assign room      = (r_pos < w) ? (w - r_pos) : '0;
    assign rem_dec   = (r_rem != '0) ? (r_rem - 8'd1) : '0;
    assign cnt_ext   = {{(POS_W-BYTE_W){1'b0}}, r_rem};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_rem      = r_rem;
        has_result = 1'b0;
        sum        = '0;
        n_out      = '0;
        case (r_phase)
            PH_SKIP: begin
                has_result  = 1'b1;
                sum         = r_pos + {{(POS_W-BYTE_W){1'b0}}, r_in_byte};
                n_out.kind  = KIND_SKIP;
                n_out.x     = r_pos[X_W-1:0];
                n_out.len   = r_in_byte;
                if (sum == w) begin
                    n_out.line_end = 1'b1;
                    n_pos          = '0;
                end else if (sum > w) begin
                    n_out.len      = room[BYTE_W-1:0];
                    n_out.line_end = 1'b1;
                    n_out.overrun  = 1'b1;
                    n_pos          = '0;
                end else begin
                    n_pos   = sum;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (r_compressed) begin
                    n_rem   = {1'b0, r_in_byte[BYTE_W-1:1]};
                    if (r_in_byte[0]) begin
                        n_phase = PH_FILL;
                    end else begin
                        n_phase = (r_in_byte[BYTE_W-1:1] != '0) ? PH_LIT : PH_SKIP;
                    end
                end else begin
                    n_rem   = r_in_byte;
                    n_phase = (r_in_byte != '0) ? PH_LIT : PH_SKIP;
                end
            end
            PH_LIT: begin
                has_result    = 1'b1;
                sum           = r_pos + 12'd1;
                n_out.kind    = KIND_LIT;
                n_out.pix     = r_in_byte;
                n_out.overrun = (r_pos >= w);
                n_out.x       = (r_pos >= w) ? '0 : r_pos[X_W-1:0];
                n_out.len     = (r_pos >= w) ? '0 : 8'd1;
                n_rem         = rem_dec;
                n_pos         = sum;
                if (rem_dec == '0) begin
                    n_phase = PH_SKIP;
                    if (sum >= w) begin
                        n_out.line_end = 1'b1;
                        n_pos          = '0;
                    end
                end
            end
            PH_FILL: begin
                has_result    = 1'b1;
                sum           = r_pos + cnt_ext;
                n_out.kind    = KIND_FILL;
                n_out.pix     = r_in_byte;
                n_out.len     = (cnt_ext < room) ? r_rem : room[BYTE_W-1:0];
                n_out.overrun = (cnt_ext > room);
                n_out.x       = (r_pos < w) ? r_pos[X_W-1:0] : '0;
                n_rem         = '0;
                n_phase       = PH_SKIP;
                n_pos         = sum;
                if (sum >= w) begin
                    n_out.line_end = 1'b1;
                    n_pos          = '0;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_pos   <= '0;
            r_rem   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-X_W-2*BYTE_W){1'b0}}, r_out.pix, r_out.len, r_out.x};
    assign o_m_tuser  = {r_out.overrun, r_out.kind};
    assign o_m_tlast  = r_out.line_end;

    `RSLD_ASSERT_NOW(a_lit_has_count, r_phase == PH_LIT, r_rem != '0)
    `RSLD_ASSERT_NOW(a_skip_pixel_zero, r_out_valid && r_out.kind == KIND_SKIP, r_out.pix == '0)
    `RSLD_ASSERT_NOW(a_overrun_ends_line,
        r_out_valid && r_out.overrun && r_out.kind != KIND_LIT, r_out.line_end)
    `RSLD_ASSERT_NEXT(a_end_clears_pos, advance && has_result && n_out.line_end, r_pos == '0)
    `RSLD_ASSERT_NEXT(a_len_no_result,
        advance && r_phase == PH_LEN && !r_out_valid, !r_out_valid)

endmodule

[tb/tb_rle_sprite_line_decoder.sv]
// Self-checking testbench for the sprite scanline run-length decoder.
`timescale 1ns / 100ps

module tb_rle_sprite_line_decoder;
    import rsld_pkg::*;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int NUM_PHASES      = 8;

    class span_scoreboard;
        int         width;
        bit         compressed;
        logic [1:0] phase;
        int         pos;
        int         remaining;
        t_span      expected_spans[$];
        int         errors;

        function new();
            width      = 0;
            compressed = 0;
            phase      = PH_SKIP;
            pos        = 0;
            remaining  = 0;
            errors     = 0;
        endfunction

        function int eff_width();
            return (width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        function void note_byte(logic [7:0] b);
            int    w;
            int    room;
            int    np;
            int    cnt;
            bit    clipped;
            bit    fill;
            t_span s;
            w    = eff_width();
            room = (pos < w) ? w - pos : 0;
            s    = '0;
            case (phase)
                PH_SKIP: begin
                    np     = pos + b;
                    s.kind = KIND_SKIP;
                    s.x    = pos[X_W-1:0];
                    if (np == w) begin
                        s.len      = b;
                        s.line_end = 1'b1;
                        pos        = 0;
                    end else if (np > w) begin
                        s.len      = room[7:0];
                        s.line_end = 1'b1;
                        s.overrun  = 1'b1;
                        pos        = 0;
                    end else begin
                        s.len = b;
                        pos   = np;
                        phase = PH_LEN;
                    end
                    expected_spans.push_back(s);
                end
                PH_LEN: begin
                    fill      = compressed && b[0];
                    cnt       = compressed ? int'(b >> 1) : int'(b);
                    remaining = cnt;
                    if (fill)
                        phase = PH_FILL;
                    else
                        phase = (cnt != 0) ? PH_LIT : PH_SKIP;
                end
                PH_LIT: begin
                    clipped   = (pos >= w);
                    s.kind    = KIND_LIT;
                    s.x       = clipped ? '0 : pos[X_W-1:0];
                    s.len     = clipped ? 8'd0 : 8'd1;
                    s.pix     = b;
                    s.overrun = clipped;
                    pos++;
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0) begin
                        phase = PH_SKIP;
                        if (pos >= w) begin
                            s.line_end = 1'b1;
                            pos        = 0;
                        end
                    end
                    expected_spans.push_back(s);
                end
                default: begin
                    cnt       = remaining & 8'hFF;
                    s.kind    = KIND_FILL;
                    s.len     = (cnt < room) ? cnt[7:0] : room[7:0];
                    s.overrun = (cnt > room);
                    s.x       = (pos < w) ? pos[X_W-1:0] : '0;
                    s.pix     = b;
                    pos       = pos + cnt;
                    remaining = 0;
                    phase     = PH_SKIP;
                    if (pos >= w) begin
                        s.line_end = 1'b1;
                        pos        = 0;
                    end
                    expected_spans.push_back(s);
                end
            endcase
        endfunction

        function void check_span(t_span got);
            t_span want;
            if (expected_spans.size() == 0) begin
                $error("unexpected span: kind %0d x %0d len %0d", got.kind, got.x, got.len);
                errors++;
                return;
            end
            want = expected_spans.pop_front();
            if (got.kind !== want.kind) begin
                $error("span_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.x !== want.x) begin
                $error("span_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.len !== want.len) begin
                $error("span_length: expected %0d, got %0d", want.len, got.len);
                errors++;
            end
            if (got.pix !== want.pix) begin
                $error("pixel_value: expected %0d, got %0d", want.pix, got.pix);
                errors++;
            end
            if (got.line_end !== want.line_end) begin
                $error("line_end: expected %0d, got %0d", want.line_end, got.line_end);
                errors++;
            end
            if (got.overrun !== want.overrun) begin
                $error("overrun: expected %0d, got %0d", want.overrun, got.overrun);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic [BYTE_W-1:0]      i_s_tdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   o_m_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    span_scoreboard sb;
    bit             no_gaps;
    bit             rx_hold_req;

    rle_sprite_line_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Mostly well-formed runs that follow the decoder's own phase, with some noise.
    function automatic logic [7:0] next_stream_byte();
        int   w;
        int   room;
        int   lim;
        int   r;
        int   cnt;
        logic [7:0] b;
        w    = sb.eff_width();
        room = (sb.pos < w) ? w - sb.pos : 0;
        r    = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        case (sb.phase)
            PH_SKIP: begin
                lim = (room > 255) ? 255 : room;
                if (r < 3)
                    return 8'(lim);
                if (r < 10)
                    return 8'($urandom_range(0, lim));
                return 8'($urandom_range(0, (lim < 6) ? lim : 6));
            end
            PH_LEN: begin
                lim = (r < 12 && room < 24) ? room : 24;
                cnt = $urandom_range(0, lim);
                if (sb.compressed)
                    b = {cnt[6:0], 1'($urandom_range(0, 1))};
                else
                    b = cnt[7:0];
                return b;
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_span got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.x        = o_m_tdata[9:0];
                got.len      = o_m_tdata[17:10];
                got.pix      = o_m_tdata[25:18];
                got.kind     = o_m_tuser[1:0];
                got.overrun  = o_m_tuser[2];
                got.line_end = o_m_tlast;
                sb.check_span(got);
            end
            if (i_s_tvalid && o_s_tready)
                sb.note_byte(i_s_tdata);
        end
    end

    initial begin
        int gap;
        gap        = 0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap         = RX_HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                gap--;
            end else begin
                i_m_tready <= 1'b1;
                if (!no_gaps)
                    gap = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_LINE_WIDTH)
            sb.width = value & 32'h7FF;
        else if (addr == ADDR_COMPRESSED)
            sb.compressed = value[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b, bit use_gen);
        int gap;
        @(negedge i_clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_tdata  <= use_gen ? next_stream_byte() : b;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic drain_spans();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] directed[] = '{8'h00, 8'h00, 8'h03, 8'h01, 8'hFF, 8'h02, 8'h04,
                                   8'h00, 8'hFF, 8'h01, 8'hFF, 8'hAA, 8'h0F, 8'h06,
                                   8'h55, 8'hAA, 8'h33, 8'hFF, 8'h11};
        int phase_width[NUM_PHASES] = '{0, 1, 1024, 2047, 100, 33, 640, 255};
        bit phase_mode[NUM_PHASES]  = '{0, 1, 1, 0, 1, 0, 1, 0};
        sb          = new();
        no_gaps     = 1'b0;
        rx_hold_req = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tdata   = '0;
        i_s_tvalid  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(ADDR_LINE_WIDTH, 17);
        write_reg(ADDR_COMPRESSED, 1);
        foreach (directed[k])
            send_byte(directed[k], 1'b0);
        drain_spans();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(ADDR_LINE_WIDTH, phase_width[p]);
            write_reg(ADDR_COMPRESSED, 32'(phase_mode[p]));
            no_gaps = (p == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == 10)
                    rx_hold_req = 1'b1;
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_spans();
                send_byte('0, 1'b1);
            end
            drain_spans();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
